[hdl/wsp_pkg.sv]
// shared constants and codes for the world-to-screen projection unit
`default_nettype none

package wsp_pkg;

  // field widths
  localparam int COORD_W = 32;
  localparam int IDX_W   = 4;
  localparam int CFG_W   = 14;
  localparam int CFG_IDX_W = 1;

  // number format and datapath sizing
  localparam int FRAC_BITS_DEF = 16;
  localparam int ACC_W  = 64;
  localparam int MUL_W  = 32;
  // ndc magnitude is clamped to 2^Q_BITS raw units
  localparam int Q_BITS = 40;
  // ndc is multiplied in two pieces, low part has LO_BITS bits
  localparam int LO_BITS = 20;

  // request codes
  localparam logic REQ_WRITE   = 1'b0;
  localparam logic REQ_PROJECT = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 14'd1920;
  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 14'd1080;

endpackage

`default_nettype wire

[hdl/wsp_channels.sv]
// valid/ready channel interfaces for requests and projection results
`default_nettype none

interface wsp_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 req_type;
  logic        [wsp_pkg::IDX_W-1:0]     matrix_index;
  logic signed [wsp_pkg::COORD_W-1:0]   coeff_value;
  logic signed [wsp_pkg::COORD_W-1:0]   pos_x;
  logic signed [wsp_pkg::COORD_W-1:0]   pos_y;
  logic signed [wsp_pkg::COORD_W-1:0]   pos_z;

  modport source (
    output valid, req_type, matrix_index, coeff_value, pos_x, pos_y, pos_z,
    input  ready
  );
  modport sink (
    input  valid, req_type, matrix_index, coeff_value, pos_x, pos_y, pos_z,
    output ready
  );
endinterface

interface wsp_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 visible;
  logic signed [wsp_pkg::COORD_W-1:0]   screen_x;
  logic signed [wsp_pkg::COORD_W-1:0]   screen_y;

  modport source (output valid, visible, screen_x, screen_y, input ready);
  modport sink   (input  valid, visible, screen_x, screen_y, output ready);
endinterface

`default_nettype wire

[hdl/world_to_screen_projection_unit.sv]
// world-to-screen projection: 4x4 matrix store, shared mac and serial divider
`default_nettype none

// channel   dir   handshake              payload
// in_if     in    valid/ready            req_type, matrix_index, coeff_value, pos_x/y/z
// out_if    out   valid/ready            visible, screen_x, screen_y
// cfg_*     in    cfg_we, no ready       cfg_index, cfg_wdata (14 bits)
//
// a matrix write is taken only while idle and gives no item
// a projection runs the three row dot products on the shared 32x32 multiplier,
// then per axis a restoring division and the screen mapping; an invisible point
// skips the division and the screen mapping
// reset zeroes the matrix and loads 1920 x 1080; the next request is taken while
// a result waits on out_if, a finished result holds the sequencer until taken

module world_to_screen_projection_unit #(
  parameter int FRAC_BITS = wsp_pkg::FRAC_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  wsp_in_if.sink                            in_if,
  wsp_out_if.source                         out_if,
  input  wire                               cfg_we,
  input  wire  [wsp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [wsp_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int ACC_W   = wsp_pkg::ACC_W;
  localparam int MUL_W   = wsp_pkg::MUL_W;
  localparam int Q_BITS  = wsp_pkg::Q_BITS;
  localparam int LO_BITS = wsp_pkg::LO_BITS;
  localparam int CW      = wsp_pkg::COORD_W;
  localparam int DIV_SH  = Q_BITS - FRAC_BITS;
  localparam int CNT_W   = $clog2(Q_BITS);
  localparam int HALF_W  = wsp_pkg::CFG_W - 1;

  localparam logic signed [ACC_W-1:0] VIS_THRESH =
    ACC_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(64'sh8000_0000);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MUL     = 4'd1;
  localparam logic [3:0] S_ACC     = 4'd2;
  localparam logic [3:0] S_CONST   = 4'd3;
  localparam logic [3:0] S_CHK     = 4'd4;
  localparam logic [3:0] S_DCAP    = 4'd5;
  localparam logic [3:0] S_DIV     = 4'd6;
  localparam logic [3:0] S_DFIN    = 4'd7;
  localparam logic [3:0] S_SMUL_HI = 4'd8;
  localparam logic [3:0] S_SACC_HI = 4'd9;
  localparam logic [3:0] S_SMUL_LO = 4'd10;
  localparam logic [3:0] S_SACC_LO = 4'd11;
  localparam logic [3:0] S_OUT     = 4'd12;

  function automatic logic signed [CW-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [CW-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[CW-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[CW-1:0];
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  // control
  logic [3:0]       state_r, state_nxt;
  logic [1:0]       row_r, row_nxt;
  logic [1:0]       term_r, term_nxt;
  logic             sel_r, sel_nxt;
  logic [CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [wsp_pkg::CFG_W-1:0] scr_w_r, scr_w_nxt;
  logic [wsp_pkg::CFG_W-1:0] scr_h_r, scr_h_nxt;
  logic signed [CW-1:0] mat_r [16];

  // datapath
  logic signed [CW-1:0]    px_r, px_nxt, py_r, py_nxt, pz_r, pz_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [ACC_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt, cw_r, cw_nxt;
  logic        [ACC_W-1:0] rem_r, rem_nxt;
  logic        [Q_BITS-1:0] nsh_r, nsh_nxt;
  logic        [Q_BITS:0]   quo_r, quo_nxt;
  logic signed [Q_BITS+1:0] ndc_r, ndc_nxt;
  logic             neg_r, neg_nxt;
  logic             vis_r, vis_nxt;
  logic signed [CW-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic             out_vis_r, out_vis_nxt;
  logic signed [CW-1:0] out_sx_r, out_sx_nxt, out_sy_r, out_sy_nxt;

  // combinational helpers
  logic                     in_take;
  logic signed [CW-1:0]     m_sel;
  logic signed [CW-1:0]     coord_sel;
  logic signed [MUL_W-1:0]  mul_a, mul_b, coef;
  logic signed [ACC_W-1:0]  mul_p;
  logic signed [ACC_W-1:0]  addend, acc_sum;
  logic signed [ACC_W-1:0]  hfix;
  logic [HALF_W-1:0]        half_w, half_h;
  logic signed [ACC_W-1:0]  num;
  logic        [ACC_W-1:0]  mag;
  logic [ACC_W+DIV_SH-1:0]  cap_lim, mag_ext;
  logic [ACC_W:0]           rem_try, den_ext, rem_sub;
  logic                     rem_ge;

  assign in_if.ready    = (state_r == S_IDLE);
  assign in_take        = in_if.valid && in_if.ready;
  assign out_if.valid   = out_valid_r;
  assign out_if.visible = out_vis_r;
  assign out_if.screen_x = out_sx_r;
  assign out_if.screen_y = out_sy_r;

  assign m_sel  = mat_r[{row_r, term_r}];
  assign half_w = scr_w_r[wsp_pkg::CFG_W-1:1];
  assign half_h = scr_h_r[wsp_pkg::CFG_W-1:1];

  always_comb begin
    unique case (term_r)
      2'd0:    coord_sel = px_r;
      2'd1:    coord_sel = py_r;
      default: coord_sel = pz_r;
    endcase
  end

  // x uses (hw + 1), y uses (1 - hh)
  always_comb begin
    if (!sel_r) begin
      coef = signed'(MUL_W'({1'b0, half_w} + {1'b0, HALF_W'(1)}));
      hfix = signed'(ACC_W'(half_w) << FRAC_BITS);
    end else begin
      coef = signed'(MUL_W'(1)) - signed'(MUL_W'(half_h));
      hfix = signed'(ACC_W'(half_h) << FRAC_BITS);
    end
  end

  // shared multiplier
  always_comb begin
    unique case (state_r)
      S_SMUL_HI: begin
        mul_a = MUL_W'(signed'(ndc_r[Q_BITS+1:LO_BITS]));
        mul_b = coef;
      end
      S_SMUL_LO: begin
        mul_a = signed'(MUL_W'(ndc_r[LO_BITS-1:0]));
        mul_b = coef;
      end
      default: begin
        mul_a = coord_sel;
        mul_b = m_sel;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // shared accumulator adder
  always_comb begin
    unique case (state_r)
      S_CONST:   addend = ACC_W'(m_sel);
      S_SACC_HI: addend = prod_r <<< LO_BITS;
      S_SACC_LO: addend = prod_r;
      default:   addend = prod_r >>> FRAC_BITS;
    endcase
  end
  assign acc_sum = acc_r + addend;

  // divider front end and restoring step
  assign num     = sel_r ? cy_r : cx_r;
  assign mag     = num[ACC_W-1] ? unsigned'(-num) : unsigned'(num);
  assign cap_lim = {cw_r, {DIV_SH{1'b0}}};
  assign mag_ext = (ACC_W+DIV_SH)'(mag);
  assign rem_try = {rem_r, nsh_r[Q_BITS-1]};
  assign den_ext = {1'b0, cw_r};
  assign rem_ge  = (rem_try >= den_ext);
  assign rem_sub = rem_try - den_ext;

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    term_nxt      = term_r;
    sel_nxt       = sel_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r;
    scr_w_nxt     = scr_w_r;
    scr_h_nxt     = scr_h_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    pz_nxt        = pz_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    cw_nxt        = cw_r;
    rem_nxt       = rem_r;
    nsh_nxt       = nsh_r;
    quo_nxt       = quo_r;
    ndc_nxt       = ndc_r;
    neg_nxt       = neg_r;
    vis_nxt       = vis_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    out_vis_nxt   = out_vis_r;
    out_sx_nxt    = out_sx_r;
    out_sy_nxt    = out_sy_r;

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      unique case (cfg_index)
        wsp_pkg::CFG_SCREEN_WIDTH:  scr_w_nxt = cfg_wdata;
        wsp_pkg::CFG_SCREEN_HEIGHT: scr_h_nxt = cfg_wdata;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_take && in_if.req_type == wsp_pkg::REQ_PROJECT) begin
          px_nxt    = in_if.pos_x;
          py_nxt    = in_if.pos_y;
          pz_nxt    = in_if.pos_z;
          acc_nxt   = '0;
          row_nxt   = 2'd0;
          term_nxt  = 2'd0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        acc_nxt  = acc_sum;
        term_nxt = term_r + 2'd1;
        // after the z term add the constant column
        state_nxt = (term_r == 2'd2) ? S_CONST : S_MUL;
      end
      S_CONST: begin
        acc_nxt  = '0;
        term_nxt = 2'd0;
        unique case (row_r)
          2'd0: begin
            cx_nxt    = acc_sum;
            row_nxt   = 2'd1;
            state_nxt = S_MUL;
          end
          2'd1: begin
            cy_nxt    = acc_sum;
            row_nxt   = 2'd3;
            state_nxt = S_MUL;
          end
          default: begin
            cw_nxt    = acc_sum;
            state_nxt = S_CHK;
          end
        endcase
      end
      S_CHK: begin
        sel_nxt = 1'b0;
        if (cw_r < VIS_THRESH) begin
          vis_nxt   = 1'b0;
          sx_nxt    = '0;
          sy_nxt    = '0;
          state_nxt = S_OUT;
        end else begin
          vis_nxt   = 1'b1;
          state_nxt = S_DCAP;
        end
      end
      S_DCAP: begin
        neg_nxt = num[ACC_W-1];
        quo_nxt = '0;
        if (mag_ext >= cap_lim) begin
          // quotient too large to matter, screen value saturates anyway
          quo_nxt   = (Q_BITS+1)'(1) << Q_BITS;
          state_nxt = S_DFIN;
        end else begin
          rem_nxt     = mag >> DIV_SH;
          nsh_nxt     = mag[Q_BITS-1:0] << FRAC_BITS;
          div_cnt_nxt = CNT_W'(Q_BITS - 1);
          state_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt = rem_ge ? rem_sub[ACC_W-1:0] : rem_try[ACC_W-1:0];
        nsh_nxt = {nsh_r[Q_BITS-2:0], 1'b0};
        quo_nxt = {quo_r[Q_BITS-1:0], rem_ge};
        div_cnt_nxt = div_cnt_r - CNT_W'(1);
        if (div_cnt_r == '0) begin
          state_nxt = S_DFIN;
        end
      end
      S_DFIN: begin
        ndc_nxt   = neg_r ? -signed'({1'b0, quo_r}) : signed'({1'b0, quo_r});
        acc_nxt   = hfix;
        state_nxt = S_SMUL_HI;
      end
      S_SMUL_HI: begin
        prod_nxt  = mul_p;
        state_nxt = S_SACC_HI;
      end
      S_SACC_HI: begin
        acc_nxt   = acc_sum;
        state_nxt = S_SMUL_LO;
      end
      S_SMUL_LO: begin
        prod_nxt  = mul_p;
        state_nxt = S_SACC_LO;
      end
      S_SACC_LO: begin
        if (!sel_r) begin
          sx_nxt    = sat32(acc_sum);
          sel_nxt   = 1'b1;
          state_nxt = S_DCAP;
        end else begin
          sy_nxt    = sat32(acc_sum);
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_vis_nxt   = vis_r;
          out_sx_nxt    = sx_r;
          out_sy_nxt    = sy_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control and matrix store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_r       <= 2'd0;
      term_r      <= 2'd0;
      sel_r       <= 1'b0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      scr_w_r     <= wsp_pkg::SCREEN_WIDTH_RST;
      scr_h_r     <= wsp_pkg::SCREEN_HEIGHT_RST;
      for (int i = 0; i < 16; i++) begin
        mat_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      term_r      <= term_nxt;
      sel_r       <= sel_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      scr_w_r     <= scr_w_nxt;
      scr_h_r     <= scr_h_nxt;
      if (in_take && in_if.req_type == wsp_pkg::REQ_WRITE) begin
        mat_r[in_if.matrix_index] <= in_if.coeff_value;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    pz_r      <= pz_nxt;
    acc_r     <= acc_nxt;
    prod_r    <= prod_nxt;
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    cw_r      <= cw_nxt;
    rem_r     <= rem_nxt;
    nsh_r     <= nsh_nxt;
    quo_r     <= quo_nxt;
    ndc_r     <= ndc_nxt;
    neg_r     <= neg_nxt;
    vis_r     <= vis_nxt;
    sx_r      <= sx_nxt;
    sy_r      <= sy_nxt;
    out_vis_r <= out_vis_nxt;
    out_sx_r  <= out_sx_nxt;
    out_sy_r  <= out_sy_nxt;
  end

endmodule

`default_nettype wire
